// File: rtl/logistic_regression_trainer_unit_defines.svh
// assertion helpers used by the checker file
`ifndef LOGISTIC_REGRESSION_TRAINER_UNIT_DEFINES_SVH
`define LOGISTIC_REGRESSION_TRAINER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LRT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lrt check failed");

// next-cycle implication, disabled during reset
`define LRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lrt check failed");

`endif

// File: rtl/lrt_pkg.sv
package lrt_pkg;

	localparam int SMP_MAX = 4096;
	localparam int FEAT_COUNT = 6;
	localparam int SIG_ENTRIES = 256;

	localparam int SMP_ADDR_W = $clog2(SMP_MAX);
	localparam int SMP_CNT_W = $clog2(SMP_MAX + 1);
	localparam int SIG_BITS = $clog2(SIG_ENTRIES);
	localparam int SIG_W = 17;
	localparam int FEAT_W = 16;
	localparam int ROW_W = 6 * FEAT_W;
	localparam int COEF_N = 7;
	localparam int Z_SPAN_W = 20;
	localparam longint Z_HALF = 524288;
	localparam longint ONE_Q16 = 65536;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EPOCH_TOTAL = 2'd1;
	localparam logic [15:0] STEP_RATE_RST = 16'd655;
	localparam logic [15:0] EPOCH_TOTAL_RST = 16'd1000;

	localparam logic [2:0] BIAS_IDX = 3'd6;
	localparam logic KIND_COEF = 1'b0;
	localparam logic KIND_PROB = 1'b1;

	typedef enum logic [1:0] {
		ACT_LOAD = 2'd0,
		ACT_TRAIN = 2'd1,
		ACT_PREDICT = 2'd2,
		ACT_CLEAR = 2'd3
	} lrt_action_t;

	typedef struct packed {
		logic [1:0] action;
		logic signed [15:0] feature_0;
		logic signed [15:0] feature_1;
		logic signed [15:0] feature_2;
		logic signed [15:0] feature_3;
		logic signed [15:0] feature_4;
		logic signed [15:0] feature_5;
		logic target_class;
	} lrt_in_item_t;

	typedef struct packed {
		logic kind;
		logic [2:0] coef_index;
		logic signed [31:0] result_value;
		logic final_res;
		logic store_overflowed;
	} lrt_out_item_t;

	typedef logic [SIG_W-1:0] sig_tab_t [SIG_ENTRIES];

	// restoring long division, elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [64:0] rem;
		quo = '0;
		rem = '0;
		for (int k = 63; k >= 0; k--) begin
			rem = {rem[63:0], num[k]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[k] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic logic [SIG_W-1:0] sig_entry(input int idx);
		longint zc;
		logic [63:0] a;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] den;
		logic [63:0] low;
		zc = -Z_HALF + ((2 * longint'(idx) + 1) * Z_HALF) / SIG_ENTRIES;
		a = (zc < 0) ? 64'(-zc) : 64'(zc);
		term = 64'd1 << 24;
		sum = term;
		for (int n = 1; n < 200; n++) begin
			if (term != 0) begin
				term = udiv64(term * a, 64'(n) * 64'(ONE_Q16));
				sum = sum + term;
			end
		end
		den = (64'd1 << 24) + sum;
		low = udiv64((64'd1 << 40) + (den >> 1), den);
		if (zc < 0)
			return SIG_W'(low);
		return SIG_W'(64'(ONE_Q16) - low);
	endfunction

	function automatic sig_tab_t build_sig_tab();
		sig_tab_t t;
		for (int i = 0; i < SIG_ENTRIES; i++)
			t[i] = sig_entry(i);
		return t;
	endfunction

	localparam sig_tab_t SIG_TABLE = build_sig_tab();

endpackage

// File: rtl/lrt_chan_if.sv
interface lrt_in_if;
	logic valid;
	logic ready;
	lrt_pkg::lrt_in_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface lrt_out_if;
	logic valid;
	logic ready;
	lrt_pkg::lrt_out_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface lrt_cfg_if;
	logic valid;
	logic ready;
	logic [lrt_pkg::CFG_IDX_W-1:0] index;
	logic [15:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/logistic_regression_trainer_unit.sv
// logistic regression trainer: loads labelled samples (six signed q8.8 features and a label)
// into a 4096-row sample memory, runs full-batch gradient descent on a train item and then
// returns the six q16.16 weights and the bias as seven result items, or returns one q0.16
// probability for a predict item. everything goes through one shared 33x18 multiplier and
// a one-bit-per-cycle divider under a small sequencer, and no new item is taken until the
// current one is finished. a load or clear item is handled in the idle state. a predict
// item waits for the output register before its result is handed out. a train item runs,
// per epoch, one pass over the stored samples (memory read, six multiply-accumulates for
// the weighted sum, sigmoid lookup, six multiply-accumulates for the gradients) and then
// an update (divide by the sample count, two multiplies by the learning rate and a
// saturating subtract per coefficient), and finally hands out the coefficients.
// training with an empty store or an epoch count of zero only hands out the coefficients.
// loads beyond capacity are dropped and set a sticky overflow flag that clear resets.
module logistic_regression_trainer_unit (
	input logic clk,
	input logic arst_n,
	lrt_cfg_if.sink cfg,
	lrt_in_if.sink cmd_ch,
	lrt_out_if.source res_ch
);

	localparam int AW = lrt_pkg::SMP_ADDR_W;
	localparam int CW = lrt_pkg::SMP_CNT_W;

	// one-hot sequencer states
	typedef enum logic [13:0] {
		S_IDLE    = 14'h0001,
		S_FETCH   = 14'h0002,
		S_ZMUL    = 14'h0004,
		S_ZACC    = 14'h0008,
		S_ERR     = 14'h0010,
		S_GMUL    = 14'h0020,
		S_GACC    = 14'h0040,
		S_DIVINIT = 14'h0080,
		S_DIV     = 14'h0100,
		S_DIVFIX  = 14'h0200,
		S_DLO     = 14'h0400,
		S_DHI     = 14'h0800,
		S_UPD     = 14'h1000,
		S_EMIT    = 14'h2000
	} lrt_state_t;

	lrt_state_t state_q;

	// configuration
	logic [15:0] step_rate_q;
	logic [15:0] epoch_total_q;

	// model and store bookkeeping
	logic [CW-1:0] count_q;
	logic ovf_q;
	logic signed [31:0] coef_q [lrt_pkg::COEF_N];
	logic signed [47:0] grad_q [lrt_pkg::COEF_N];

	// sample memory, one row per sample: {label, feature_5 .. feature_0}
	logic [lrt_pkg::ROW_W:0] smp_mem [lrt_pkg::SMP_MAX];
	logic [lrt_pkg::ROW_W:0] mem_rd_q;
	logic [lrt_pkg::ROW_W-1:0] pred_row_q;
	logic use_mem_q;

	// datapath registers
	logic signed [47:0] z_q;
	logic signed [50:0] prod_q;
	logic signed [17:0] err_q;
	logic [47:0] div_q;
	logic [CW-1:0] rem_q;
	logic neg_q;
	logic [5:0] cnt_q;
	logic signed [17:0] rnd_q;
	logic [2:0] j_q;
	logic [AW-1:0] s_q;
	logic [15:0] ep_q;

	// output register
	lrt_pkg::lrt_out_item_t out_q;
	logic out_valid_q;

	logic in_acc;
	logic out_free;
	logic out_load;
	logic [lrt_pkg::ROW_W-1:0] in_row;
	logic [lrt_pkg::ROW_W-1:0] row_cur;
	logic signed [15:0] x_cur;

	// shared multiplier
	logic signed [32:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [50:0] mul_p;

	// sigmoid lookup
	logic signed [47:0] z_off;
	logic [lrt_pkg::SIG_BITS-1:0] sig_idx;
	logic [lrt_pkg::SIG_W-1:0] sig_val;
	logic signed [17:0] err_c;

	// divider step
	logic [CW:0] div_sh;
	logic div_ge;
	logic [CW:0] div_rem;

	// coefficient update
	logic signed [51:0] rnd_sum;
	logic signed [51:0] delta;
	logic signed [52:0] new_coef;
	logic signed [31:0] sat_coef;

	assign cfg.ready = 1'b1;
	assign cmd_ch.ready = (state_q == S_IDLE);
	assign in_acc = cmd_ch.valid && cmd_ch.ready;
	assign out_free = !out_valid_q || res_ch.ready;
	assign res_ch.valid = out_valid_q;
	assign res_ch.item = out_q;

	// a result item enters the output register in these states
	assign out_load = out_free && ((state_q == S_ERR && !use_mem_q) || state_q == S_EMIT);

	assign in_row = {cmd_ch.item.feature_5, cmd_ch.item.feature_4, cmd_ch.item.feature_3,
		cmd_ch.item.feature_2, cmd_ch.item.feature_1, cmd_ch.item.feature_0};
	assign row_cur = use_mem_q ? mem_rd_q[lrt_pkg::ROW_W-1:0] : pred_row_q;
	assign x_cur = row_cur[lrt_pkg::FEAT_W*j_q +: lrt_pkg::FEAT_W];

	// operand select for the one multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_ZMUL: begin
				mul_a = 33'(coef_q[j_q]);
				mul_b = 18'(x_cur);
			end
			S_GMUL: begin
				mul_a = 33'(x_cur);
				mul_b = err_q;
			end
			S_DLO: begin
				// low 24 bits of the mean, unsigned
				mul_a = {9'd0, div_q[23:0]};
				mul_b = {2'b00, step_rate_q};
			end
			S_DHI: begin
				// mean >>> 24, signed
				mul_a = 33'($signed(div_q[47:24]));
				mul_b = {2'b00, step_rate_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// z in [-8, 8) picks a table entry, outside it clamps to the ends
	assign z_off = z_q + 48'(lrt_pkg::Z_HALF);
	always_comb begin
		if (z_q < -48'sd524288)
			sig_idx = '0;
		else if (z_q >= 48'sd524288)
			sig_idx = '1;
		else
			sig_idx = z_off[lrt_pkg::Z_SPAN_W-1 -: lrt_pkg::SIG_BITS];
	end
	assign sig_val = lrt_pkg::SIG_TABLE[sig_idx];
	assign err_c = $signed({1'b0, sig_val})
		- (mem_rd_q[lrt_pkg::ROW_W] ? 18'sd65536 : 18'sd0);

	// restoring divide of |sum| by the sample count
	assign div_sh = {rem_q, div_q[47]};
	assign div_ge = div_sh >= {1'b0, count_q};
	assign div_rem = div_ge ? (div_sh - {1'b0, count_q}) : div_sh;

	// delta = step * hi + round(step * lo / 2^24), then saturating subtract
	assign rnd_sum = 52'(prod_q) + 52'sd8388608;
	assign delta = 52'(prod_q) + 52'(rnd_q);
	assign new_coef = 53'(coef_q[j_q]) - 53'(delta);
	always_comb begin
		if (new_coef > 53'sd2147483647)
			sat_coef = 32'sh7fffffff;
		else if (new_coef < -53'sd2147483648)
			sat_coef = 32'sh80000000;
		else
			sat_coef = new_coef[31:0];
	end

	// sample memory write and read
	always_ff @(posedge clk) begin
		if (in_acc && cmd_ch.item.action == lrt_pkg::ACT_LOAD
				&& count_q < CW'(lrt_pkg::SMP_MAX))
			smp_mem[count_q[AW-1:0]] <= {cmd_ch.item.target_class, in_row};
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FETCH)
			mem_rd_q <= smp_mem[s_q];
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_rate_q <= lrt_pkg::STEP_RATE_RST;
			epoch_total_q <= lrt_pkg::EPOCH_TOTAL_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				lrt_pkg::REG_STEP_RATE: step_rate_q <= cfg.data;
				lrt_pkg::REG_EPOCH_TOTAL: epoch_total_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// output valid: set on a load, cleared once the item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ovf_q <= 1'b0;
			for (int i = 0; i < lrt_pkg::COEF_N; i++)
				coef_q[i] <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (cmd_ch.item.action)
							lrt_pkg::ACT_LOAD: begin
								if (count_q < CW'(lrt_pkg::SMP_MAX))
									count_q <= count_q + 1'b1;
								else
									ovf_q <= 1'b1;
							end
							lrt_pkg::ACT_TRAIN: begin
								j_q <= '0;
								if (count_q == '0 || epoch_total_q == '0) begin
									state_q <= S_EMIT;
								end else begin
									ep_q <= '0;
									s_q <= '0;
									use_mem_q <= 1'b1;
									state_q <= S_FETCH;
								end
							end
							lrt_pkg::ACT_PREDICT: begin
								pred_row_q <= in_row;
								use_mem_q <= 1'b0;
								z_q <= 48'(coef_q[lrt_pkg::BIAS_IDX]);
								j_q <= '0;
								state_q <= S_ZMUL;
							end
							lrt_pkg::ACT_CLEAR: begin
								count_q <= '0;
								ovf_q <= 1'b0;
								for (int i = 0; i < lrt_pkg::COEF_N; i++)
									coef_q[i] <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_FETCH: begin
					// gradient sums restart with the first sample of each epoch
					if (s_q == '0) begin
						for (int i = 0; i < lrt_pkg::COEF_N; i++)
							grad_q[i] <= '0;
					end
					z_q <= 48'(coef_q[lrt_pkg::BIAS_IDX]);
					j_q <= '0;
					state_q <= S_ZMUL;
				end
				S_ZMUL: begin
					prod_q <= mul_p;
					state_q <= S_ZACC;
				end
				S_ZACC: begin
					z_q <= z_q + 48'(prod_q >>> 8);
					if (j_q == 3'(lrt_pkg::FEAT_COUNT - 1)) begin
						state_q <= S_ERR;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_ZMUL;
					end
				end
				S_ERR: begin
					if (!use_mem_q) begin
						if (out_free) begin
							out_q.kind <= lrt_pkg::KIND_PROB;
							out_q.coef_index <= '0;
							out_q.result_value <= 32'({1'b0, sig_val});
							out_q.final_res <= 1'b1;
							out_q.store_overflowed <= ovf_q;
							state_q <= S_IDLE;
						end
					end else begin
						err_q <= err_c;
						grad_q[lrt_pkg::BIAS_IDX] <= grad_q[lrt_pkg::BIAS_IDX]
							+ (48'(err_c) <<< 8);
						j_q <= '0;
						state_q <= S_GMUL;
					end
				end
				S_GMUL: begin
					prod_q <= mul_p;
					state_q <= S_GACC;
				end
				S_GACC: begin
					grad_q[j_q] <= grad_q[j_q] + prod_q[47:0];
					if (j_q == 3'(lrt_pkg::FEAT_COUNT - 1)) begin
						if ({1'b0, s_q} == count_q - 1'b1) begin
							j_q <= '0;
							state_q <= S_DIVINIT;
						end else begin
							s_q <= s_q + 1'b1;
							state_q <= S_FETCH;
						end
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_GMUL;
					end
				end
				S_DIVINIT: begin
					neg_q <= grad_q[j_q][47];
					div_q <= grad_q[j_q][47] ? 48'(-grad_q[j_q]) : grad_q[j_q];
					rem_q <= '0;
					cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= div_rem[CW-1:0];
					div_q <= {div_q[46:0], div_ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd47)
						state_q <= S_DIVFIX;
				end
				S_DIVFIX: begin
					// quotient truncates toward zero
					if (neg_q)
						div_q <= -div_q;
					state_q <= S_DLO;
				end
				S_DLO: begin
					prod_q <= mul_p;
					state_q <= S_DHI;
				end
				S_DHI: begin
					rnd_q <= rnd_sum[41:24];
					prod_q <= mul_p;
					state_q <= S_UPD;
				end
				S_UPD: begin
					coef_q[j_q] <= sat_coef;
					if (j_q == lrt_pkg::BIAS_IDX) begin
						j_q <= '0;
						if (ep_q == epoch_total_q - 1'b1) begin
							state_q <= S_EMIT;
						end else begin
							ep_q <= ep_q + 1'b1;
							s_q <= '0;
							state_q <= S_FETCH;
						end
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= S_DIVINIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_q.kind <= lrt_pkg::KIND_COEF;
						out_q.coef_index <= j_q;
						out_q.result_value <= coef_q[j_q];
						out_q.final_res <= (j_q == lrt_pkg::BIAS_IDX);
						out_q.store_overflowed <= ovf_q;
						if (j_q == lrt_pkg::BIAS_IDX)
							state_q <= S_IDLE;
						else
							j_q <= j_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/lrt_checker.sv
`include "logistic_regression_trainer_unit_defines.svh"

module lrt_checker (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic [1:0] cmd_action,
	input logic res_valid,
	input logic res_ready,
	input lrt_pkg::lrt_out_item_t res_item
);

	// a train or predict item keeps the block busy
	`LRT_ASSERT_NEXT(a_busy_after_run, clk, arst_n, cmd_valid && cmd_ready && (cmd_action == lrt_pkg::ACT_TRAIN || cmd_action == lrt_pkg::ACT_PREDICT), !cmd_ready)

	// no new item while a run still has results to hand out
	`LRT_ASSERT_IMPL(a_busy_mid_run, clk, arst_n, res_valid && !res_item.final_res, !cmd_ready)

	// a stalled result holds
	`LRT_ASSERT_NEXT(a_out_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_item))

endmodule

bind logistic_regression_trainer_unit lrt_checker u_lrt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cmd_valid(cmd_ch.valid),
	.cmd_ready(cmd_ch.ready),
	.cmd_action(cmd_ch.item.action),
	.res_valid(res_ch.valid),
	.res_ready(res_ch.ready),
	.res_item(res_ch.item)
);
